/* design/aabb_frustum_test_unit_defines.svh */
// ----------------------------------------------------------------------------
// aabb frustum test unit assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_TEST_UNIT_DEFINES_SVH
`define AABB_FRUSTUM_TEST_UNIT_DEFINES_SVH

// same-cycle implication
`define AFT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/aft_pkg.sv */
// ----------------------------------------------------------------------------
// aft_pkg
// widths, plane field layout and pipeline control types for the box culler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aft_pkg;

	localparam int COORD_W        = 24;  // Q15.8 box coordinates
	localparam int TAG_W          = 16;
	localparam int NRM_W          = 12;  // Q1.10 normal components
	localparam int OFS_W          = 28;  // Q19.8 plane offset
	localparam int PLANE_W        = 64;
	localparam int PLANE_REGS     = 6;
	localparam int NUM_PLANES_DEF = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int AXES           = 3;

	localparam int C2_W    = COORD_W + 1;        // doubled center / extent
	localparam int ANRM_W  = NRM_W + 1;          // |n| as a signed operand
	localparam int PROD_W  = NRM_W + C2_W;       // n * c2, e2 * |n|
	localparam int DIST_W  = 40;                 // 2*dist, Q.18
	localparam int CULL_W  = DIST_W + 1;         // dist2 + rsum
	localparam int HALF_W  = DIST_W / 2;         // split of |dist2|
	localparam int PP_W    = 2 * HALF_W;         // one partial square
	localparam int SQ_W    = 2 * DIST_W;         // dist2 squared
	localparam int ESQ_W   = 2 * COORD_W;        // one squared extent
	localparam int EE_W    = ESQ_W + 2;          // sum of three
	localparam int EE_SHIFT = 20;                // Q.16 up to Q.36
	localparam int D_SHIFT  = 11;                // Q.8 offset, doubled, up to Q.18

	// plane register field positions
	localparam int NX_LSB  = 0;
	localparam int NY_LSB  = 12;
	localparam int NZ_LSB  = 24;
	localparam int OFS_LSB = 36;

	// load enables for the lane stages
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} aft_adv_t;

	function automatic logic signed [NRM_W-1:0] plane_nrm(
		input logic [PLANE_W-1:0] p,
		input logic [1:0] axis
	);
		logic [PLANE_W-1:0] sh;
		sh = p >> (axis * NRM_W);
		return sh[NRM_W-1:0];
	endfunction

	function automatic logic signed [OFS_W-1:0] plane_ofs(input logic [PLANE_W-1:0] p);
		return p[OFS_LSB +: OFS_W];
	endfunction

endpackage

/* design/aft_plane_regs.sv */
// ----------------------------------------------------------------------------
// aft_plane_regs
// frustum plane register file, written through the configuration port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aft_plane_regs
	import aft_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PLANE_W-1:0]   cfg_data,
	output logic [PLANE_W-1:0]   plane_q [PLANE_REGS]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_REGS; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(PLANE_REGS))) begin
			plane_q[cfg_index] <= cfg_data;
		end
	end

endmodule

/* design/aft_plane_lane.sv */
// ----------------------------------------------------------------------------
// aft_plane_lane
// one plane of the cull test, stages s2 to s5, cull flag out of s5
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aft_plane_lane
	import aft_pkg::*;
(
	input  logic                    clk,
	input  aft_adv_t                adv,
	input  logic [PLANE_W-1:0]      plane,
	input  logic signed [C2_W-1:0]  c2_s1 [AXES],
	input  logic signed [C2_W-1:0]  e2_s1 [AXES],
	input  logic [EE_W-1:0]         ee_s5,
	output logic                    cull
);

	logic signed [PROD_W-1:0] pn_s2 [AXES];
	logic signed [PROD_W-1:0] pe_s2 [AXES];
	logic signed [DIST_W-1:0] dist_s3;
	logic signed [DIST_W-1:0] rsum_s3;
	logic [DIST_W-1:0]        mag_s4;
	logic                     neg_s4;
	logic                     cullb_s4;
	logic [PP_W-1:0]          hh_s5;
	logic [PP_W-1:0]          hl_s5;
	logic [PP_W-1:0]          ll_s5;
	logic                     neg_s5;
	logic                     cullb_s5;

	logic signed [PROD_W-1:0]  pn_c [AXES];
	logic signed [PROD_W-1:0]  pe_c [AXES];
	logic signed [DIST_W-1:0]  dist_c;
	logic signed [DIST_W-1:0]  rsum_c;
	logic signed [CULL_W-1:0]  tot_c;
	logic [SQ_W-1:0]           sq_c;
	logic [SQ_W-1:0]           ee_sh_c;

	// s2: per-axis products
	always_comb begin
		logic signed [NRM_W-1:0]    n;
		logic signed [ANRM_W-1:0]   an;
		logic signed [PROD_W:0]     pe_full;
		for (int k = 0; k < AXES; k++) begin
			n        = plane_nrm(plane, 2'(k));
			an       = n[NRM_W-1] ? -ANRM_W'(n) : ANRM_W'(n);
			pn_c[k]  = n * c2_s1[k];
			pe_full  = e2_s1[k] * an;
			pe_c[k]  = pe_full[PROD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			pn_s2 <= pn_c;
			pe_s2 <= pe_c;
		end
	end

	// s3: signed distance and weighted extent
	always_comb begin
		logic signed [DIST_W-1:0] dsh;
		dsh    = DIST_W'(plane_ofs(plane)) <<< D_SHIFT;
		dist_c = DIST_W'(pn_s2[0]) + DIST_W'(pn_s2[1]) + DIST_W'(pn_s2[2]) + dsh;
		rsum_c = DIST_W'(pe_s2[0]) + DIST_W'(pe_s2[1]) + DIST_W'(pe_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			dist_s3 <= dist_c;
			rsum_s3 <= rsum_c;
		end
	end

	// s4: magnitude of the distance, extent test
	assign tot_c = CULL_W'(dist_s3) + CULL_W'(rsum_s3);

	always_ff @(posedge clk) begin
		if (adv.ld_s4) begin
			neg_s4   <= dist_s3[DIST_W-1];
			mag_s4   <= dist_s3[DIST_W-1] ? DIST_W'(-dist_s3) : DIST_W'(dist_s3);
			cullb_s4 <= tot_c[CULL_W-1];
		end
	end

	// s5: square as three partial products
	always_ff @(posedge clk) begin
		if (adv.ld_s5) begin
			hh_s5    <= mag_s4[DIST_W-1:HALF_W] * mag_s4[DIST_W-1:HALF_W];
			hl_s5    <= mag_s4[DIST_W-1:HALF_W] * mag_s4[HALF_W-1:0];
			ll_s5    <= mag_s4[HALF_W-1:0] * mag_s4[HALF_W-1:0];
			neg_s5   <= neg_s4;
			cullb_s5 <= cullb_s4;
		end
	end

	// radius test: dist below zero and dist^2 above e.e
	assign sq_c    = {hh_s5, {PP_W{1'b0}}} + (SQ_W'(hl_s5) << (HALF_W + 1)) + SQ_W'(ll_s5);
	assign ee_sh_c = SQ_W'(ee_s5) << EE_SHIFT;
	assign cull    = cullb_s5 | (neg_s5 & (sq_c > ee_sh_c));

endmodule

/* design/aabb_frustum_test_unit.sv */
// ----------------------------------------------------------------------------
// aabb_frustum_test_unit
// culls one axis-aligned box per transfer against the configured frustum planes
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                   payload
//   cfg       in          cfg_we                      cfg_index, cfg_data
//   box       in          box_valid / box_stall       min_*, max_*, box_tag
//   res       out         res_valid / res_stall       tag_out, inside_res
//
// one box per cycle while res_stall is low; a box passes the stages in order
// (s1 center/extent, s2 products, s3 sums, s4 magnitude, s5 squares, s6 result)
// the rate is set by the per-plane lanes, each one full pipeline with its own
// multipliers, so nothing is shared between boxes
// reset clears the valid bits and the plane registers (all-zero planes never cull)
// res_stall holds only the stages that are full; empty stages behind keep filling
//
`timescale 1ns / 1ps

module aabb_frustum_test_unit
	import aft_pkg::*;
#(
	parameter int NUM_PLANES = NUM_PLANES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [PLANE_W-1:0]        cfg_data,
	// box channel
	input  logic                      box_valid,
	output logic                      box_stall,
	input  logic signed [COORD_W-1:0] min_x,
	input  logic signed [COORD_W-1:0] min_y,
	input  logic signed [COORD_W-1:0] min_z,
	input  logic signed [COORD_W-1:0] max_x,
	input  logic signed [COORD_W-1:0] max_y,
	input  logic signed [COORD_W-1:0] max_z,
	input  logic [TAG_W-1:0]          box_tag,
	// result channel
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [TAG_W-1:0]          tag_out,
	output logic                      inside_res
);

	`include "aabb_frustum_test_unit_defines.svh"

	// plane registers
	logic [PLANE_W-1:0] plane_q [PLANE_REGS];

	aft_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.plane_q   (plane_q)
	);

	// valid bits and per-stage load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld_s1, ld_s6;
	aft_adv_t adv;

	// a stage loads when it is empty or its contents move on
	assign ld_s6     = !v_s6 || !res_stall;
	assign adv.ld_s5 = !v_s5 || ld_s6;
	assign adv.ld_s4 = !v_s4 || adv.ld_s5;
	assign adv.ld_s3 = !v_s3 || adv.ld_s4;
	assign adv.ld_s2 = !v_s2 || adv.ld_s3;
	assign ld_s1     = !v_s1 || adv.ld_s2;
	assign box_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld_s1)     v_s1 <= box_valid;
			if (adv.ld_s2) v_s2 <= v_s1;
			if (adv.ld_s3) v_s3 <= v_s2;
			if (adv.ld_s4) v_s4 <= v_s3;
			if (adv.ld_s5) v_s5 <= v_s4;
			if (ld_s6)     v_s6 <= v_s5;
		end
	end

	// s1: doubled center and extent, kept exact
	logic signed [C2_W-1:0] c2_s1 [AXES];
	logic signed [C2_W-1:0] e2_s1 [AXES];
	logic [TAG_W-1:0]       tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			c2_s1[0] <= C2_W'(min_x) + C2_W'(max_x);
			c2_s1[1] <= C2_W'(min_y) + C2_W'(max_y);
			c2_s1[2] <= C2_W'(min_z) + C2_W'(max_z);
			e2_s1[0] <= C2_W'(max_x) - C2_W'(min_x);
			e2_s1[1] <= C2_W'(max_y) - C2_W'(min_y);
			e2_s1[2] <= C2_W'(max_z) - C2_W'(min_z);
			tag_s1   <= box_tag;
		end
	end

	// squared extent length, shared by all planes
	logic [ESQ_W-1:0] esq_s2 [AXES];
	logic [EE_W-1:0]  ee_s3, ee_s4, ee_s5;
	logic signed [2*C2_W-1:0] esq_c [AXES];

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			esq_c[k] = e2_s1[k] * e2_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			for (int k = 0; k < AXES; k++) begin
				esq_s2[k] <= esq_c[k][ESQ_W-1:0];
			end
			tag_s2 <= tag_s1;
		end
		if (adv.ld_s3) begin
			ee_s3  <= EE_W'(esq_s2[0]) + EE_W'(esq_s2[1]) + EE_W'(esq_s2[2]);
			tag_s3 <= tag_s2;
		end
		if (adv.ld_s4) begin
			ee_s4  <= ee_s3;
			tag_s4 <= tag_s3;
		end
		if (adv.ld_s5) begin
			ee_s5  <= ee_s4;
			tag_s5 <= tag_s4;
		end
	end

	// one lane per plane; planes past the register file read as zero
	logic [NUM_PLANES-1:0] cull_vec;

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
		logic [PLANE_W-1:0] lane_plane;

		if (i < PLANE_REGS) begin : g_reg
			assign lane_plane = plane_q[i];
		end else begin : g_zero
			assign lane_plane = '0;
		end

		aft_plane_lane u_lane (
			.clk   (clk),
			.adv   (adv),
			.plane (lane_plane),
			.c2_s1 (c2_s1),
			.e2_s1 (e2_s1),
			.ee_s5 (ee_s5),
			.cull  (cull_vec[i])
		);
	end

	// s6: output register, inside unless some plane culls
	logic inside_s6;

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			inside_s6 <= ~|cull_vec;
			tag_s6    <= tag_s5;
		end
	end

	assign res_valid  = v_s6;
	assign tag_out    = tag_s6;
	assign inside_res = inside_s6;

	// pipeline bookkeeping checks
	`AFT_ASSERT_NEXT(a_take_fills_s1, box_valid && !box_stall, v_s1,
		"accepted box did not reach stage 1")
	`AFT_ASSERT_NEXT(a_s5_moves_out, v_s5 && ld_s6, res_valid,
		"stage 5 item lost on its way to the output")
	`AFT_ASSERT_SAME(a_stall_only_full, box_stall, v_s1 && v_s2,
		"box channel stalled with room in the pipeline")
	`AFT_ASSERT_NEXT(a_no_repeat, res_valid && !res_stall && !v_s5, !res_valid,
		"result repeated after its transfer")

endmodule
